// ===== sv/mahd_pkg.sv =====
// Shared types, constants and lookup tables for the MPEG audio header decoder.
`default_nettype none

package mahd_pkg;

  // Width of the offset adder; the result port keeps its low 32 bits.
  localparam int OFFSET_BITS = 32;

  // Divider shape: the dividend fits in 26 bits and the quotient in 11 bits.
  localparam int NUM_BITS = 26;
  localparam int QUO_BITS = 11;
  localparam int RATE_BITS = 16;
  localparam int FACTOR_BITS = 18;

  // Clock edges from the one that accepts an item to the one that accepts its result.
  localparam int LATENCY = QUO_BITS + 2;

  // Layer codes of header byte 1, bits 2 to 1.
  localparam logic [1:0] LCODE_RESERVED = 2'b00;
  localparam logic [1:0] LCODE_LAYER3   = 2'b01;
  localparam logic [1:0] LCODE_LAYER2   = 2'b10;
  localparam logic [1:0] LCODE_LAYER1   = 2'b11;

  // Decoded layer numbers.
  localparam logic [1:0] LAYER_NONE  = 2'd0;
  localparam logic [1:0] LAYER_ONE   = 2'd1;
  localparam logic [1:0] LAYER_TWO   = 2'd2;
  localparam logic [1:0] LAYER_THREE = 2'd3;

  // Special index codes.
  localparam logic [1:0] RATE_IDX_RESERVED = 2'd3;
  localparam logic [3:0] BR_IDX_FREE       = 4'd0;
  localparam logic [3:0] BR_IDX_BAD        = 4'd15;
  localparam logic [1:0] MODE_JOINT        = 2'd1;

  // Versions.
  localparam logic VERSION_MPEG1 = 1'b0;
  localparam logic VERSION_MPEG2 = 1'b1;

  // Bitrate table rows.
  localparam logic [2:0] ROW_M1_L1  = 3'd0;
  localparam logic [2:0] ROW_M1_L2  = 3'd1;
  localparam logic [2:0] ROW_M1_L3  = 3'd2;
  localparam logic [2:0] ROW_M2_L1  = 3'd3;
  localparam logic [2:0] ROW_M2_L23 = 3'd4;

  // Slot factors times 1000 (bits per kbit), so kbps goes straight in.
  localparam logic [FACTOR_BITS-1:0] FACTOR_L1    = 18'd12000;
  localparam logic [FACTOR_BITS-1:0] FACTOR_L23   = 18'd144000;
  localparam logic [FACTOR_BITS-1:0] FACTOR_M2_L3 = 18'd72000;

  // Bitrates in kbit/s, one row per version and layer group.
  localparam logic [8:0] KBPS_TABLE [5][16] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  // Sample rates in Hz by version and rate index.
  localparam logic [RATE_BITS-1:0] RATE_TABLE [2][4] = '{
    '{16'd44100, 16'd48000, 16'd32000, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0}
  };

  // One input item.
  typedef struct packed {
    logic [7:0]  header_byte1;
    logic [7:0]  header_byte2;
    logic [7:0]  header_byte3;
    logic [31:0] frame_offset;
  } in_t;

  // One result item.
  typedef struct packed {
    logic        status;
    logic        version;
    logic [1:0]  layer;
    logic        crc_present;
    logic [15:0] sample_rate_hz;
    logic        padded;
    logic [8:0]  bitrate_kbps;
    logic [10:0] frame_length;
    logic [1:0]  chan_mode;
    logic [1:0]  joint_extension;
    logic [31:0] data_offset;
  } out_t;

  // What one divider cell hands to the next.
  typedef struct packed {
    logic                valid;
    logic [NUM_BITS-1:0] rem;
    logic [NUM_BITS-1:0] dvs;
    logic [QUO_BITS-1:0] quo;
    out_t                res;
  } div_stage_t;

endpackage

`default_nettype wire

// ===== sv/mpeg_audio_header_decoder.sv =====
// Top level of the MPEG audio frame header decoder.
//
// One header item is taken in every clock cycle; busy never rises. Each item gives
// exactly one result, shown on out_item with out_strobe high for one cycle. Between
// the edge at which start was taken and the strobe lie the decode stage (table lookups
// and the dividend multiply), a row of 11 divider cells, each resolving one bit of the
// frame length quotient, and the output register. The receiver cannot stall, so results
// must be captured on the cycle they appear.
`default_nettype none

module mpeg_audio_header_decoder (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire mahd_pkg::in_t  in_item,
  output logic                out_strobe,
  output mahd_pkg::out_t      out_item
);

  mahd_pkg::div_stage_t chain [mahd_pkg::QUO_BITS+1];

  logic                        out_strobe_r;
  logic                        out_strobe_nxt;
  mahd_pkg::out_t              out_item_r;
  mahd_pkg::out_t              out_item_nxt;
  mahd_pkg::div_stage_t        last;
  logic [mahd_pkg::QUO_BITS-1:0] slots;

  // The pipeline takes an item every cycle.
  assign busy = 1'b0;

  mahd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (start & ~busy),
    .item      (in_item),
    .stage_out (chain[0])
  );

  // Divider row, most significant quotient bit first.
  for (genvar i = 0; i < mahd_pkg::QUO_BITS; i++) begin : g_cell
    mahd_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  assign last = chain[mahd_pkg::QUO_BITS];

  // Padding and the layer I slot size of four bytes are applied after the divide.
  always_comb begin
    slots          = last.quo + mahd_pkg::QUO_BITS'(last.res.padded);
    out_strobe_nxt = last.valid;
    out_item_nxt   = last.res;
    if (last.res.status) begin
      out_item_nxt.frame_length = '0;
    end else if (last.res.layer == mahd_pkg::LAYER_ONE) begin
      out_item_nxt.frame_length = 11'({slots, 2'b00});
    end else begin
      out_item_nxt.frame_length = 11'(slots);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Every accepted item comes out after the fixed latency.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(mahd_pkg::LATENCY) out_strobe)
    else $error("result strobe missing after fixed latency");

  // A valid header always has a nonzero length, an error header none.
  a_len_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.status) |-> (out_item.frame_length != 11'd0))
    else $error("valid header with zero frame length");

  a_len_err : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status) |-> (out_item.frame_length == 11'd0))
    else $error("error header with nonzero frame length");

  // A reserved layer is always flagged as an error.
  a_layer : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.layer == mahd_pkg::LAYER_NONE) |-> out_item.status)
    else $error("reserved layer not flagged");

endmodule

`default_nettype wire

// ===== sv/mahd_decode.sv =====
// Front stage: field decode, table lookups, dividend product and data offset.
`default_nettype none

module mahd_decode (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire mahd_pkg::in_t       item,
  output mahd_pkg::div_stage_t     stage_out
);

  mahd_pkg::div_stage_t            stage_r;
  mahd_pkg::div_stage_t            stage_nxt;

  logic                            version;
  logic [1:0]                      layer;
  logic [2:0]                      row;
  logic [3:0]                      br_idx;
  logic [1:0]                      rate_idx;
  logic [1:0]                      mode;
  logic [8:0]                      kbps;
  logic [mahd_pkg::RATE_BITS-1:0]  rate;
  logic [mahd_pkg::FACTOR_BITS-1:0] factor;
  logic                            err;
  logic [mahd_pkg::FACTOR_BITS+8:0] product;
  logic [mahd_pkg::OFFSET_BITS-1:0] offset_sum;

  // Field decode.
  always_comb begin
    version  = ~item.header_byte1[3];
    br_idx   = item.header_byte2[7:4];
    rate_idx = item.header_byte2[3:2];
    mode     = item.header_byte3[7:6];
    rate     = mahd_pkg::RATE_TABLE[version][rate_idx];

    unique case (item.header_byte1[2:1])
      mahd_pkg::LCODE_LAYER3: layer = mahd_pkg::LAYER_THREE;
      mahd_pkg::LCODE_LAYER2: layer = mahd_pkg::LAYER_TWO;
      mahd_pkg::LCODE_LAYER1: layer = mahd_pkg::LAYER_ONE;
      default:                layer = mahd_pkg::LAYER_NONE;
    endcase

    // Bitrate row and slot factor follow version and layer.
    if (version == mahd_pkg::VERSION_MPEG1) begin
      if (layer == mahd_pkg::LAYER_ONE) begin
        row = mahd_pkg::ROW_M1_L1;
      end else if (layer == mahd_pkg::LAYER_TWO) begin
        row = mahd_pkg::ROW_M1_L2;
      end else begin
        row = mahd_pkg::ROW_M1_L3;
      end
    end else begin
      row = (layer == mahd_pkg::LAYER_ONE) ? mahd_pkg::ROW_M2_L1 : mahd_pkg::ROW_M2_L23;
    end

    if (layer == mahd_pkg::LAYER_ONE) begin
      factor = mahd_pkg::FACTOR_L1;
    end else if (version == mahd_pkg::VERSION_MPEG2 &&
                 layer == mahd_pkg::LAYER_THREE) begin
      factor = mahd_pkg::FACTOR_M2_L3;
    end else begin
      factor = mahd_pkg::FACTOR_L23;
    end

    kbps = (layer == mahd_pkg::LAYER_NONE) ? 9'd0 : mahd_pkg::KBPS_TABLE[row][br_idx];

    err = (layer == mahd_pkg::LAYER_NONE) || (rate_idx == mahd_pkg::RATE_IDX_RESERVED) ||
          (br_idx == mahd_pkg::BR_IDX_FREE) || (br_idx == mahd_pkg::BR_IDX_BAD);

    // The dividend is factor times kbps; it stays below 2^26 for all table entries.
    product = factor * kbps;

    offset_sum = mahd_pkg::OFFSET_BITS'(item.frame_offset) +
                 mahd_pkg::OFFSET_BITS'(32) +
                 (item.header_byte1[0] ? mahd_pkg::OFFSET_BITS'(0) :
                                         mahd_pkg::OFFSET_BITS'(2));
  end

  // Assemble the item for the first divider cell.
  always_comb begin
    stage_nxt                     = '0;
    stage_nxt.valid               = take;
    stage_nxt.rem                 = err ? '0 : product[mahd_pkg::NUM_BITS-1:0];
    stage_nxt.dvs                 = mahd_pkg::NUM_BITS'({rate, {(mahd_pkg::QUO_BITS-1){1'b0}}});
    stage_nxt.quo                 = '0;
    stage_nxt.res.status          = err;
    stage_nxt.res.version         = version;
    stage_nxt.res.layer           = layer;
    stage_nxt.res.crc_present     = ~item.header_byte1[0];
    stage_nxt.res.sample_rate_hz  = rate;
    stage_nxt.res.padded          = item.header_byte2[1];
    stage_nxt.res.bitrate_kbps    = kbps;
    stage_nxt.res.frame_length    = '0;
    stage_nxt.res.chan_mode       = mode;
    stage_nxt.res.joint_extension = (mode == mahd_pkg::MODE_JOINT) ? item.header_byte3[5:4] : 2'd0;
    stage_nxt.res.data_offset     = 32'(offset_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.rem <= stage_nxt.rem;
    stage_r.dvs <= stage_nxt.dvs;
    stage_r.quo <= stage_nxt.quo;
    stage_r.res <= stage_nxt.res;
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire

// ===== sv/mahd_div_cell.sv =====
// One restoring-division cell: produces one quotient bit and passes the item on.
`default_nettype none

module mahd_div_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mahd_pkg::div_stage_t  stage_in,
  output mahd_pkg::div_stage_t       stage_out
);

  mahd_pkg::div_stage_t          stage_r;
  mahd_pkg::div_stage_t          stage_nxt;
  logic [mahd_pkg::NUM_BITS:0]   diff;
  logic                          fits;

  // Trial subtract of the shifted divisor; keep it when it does not go negative.
  always_comb begin
    diff      = {1'b0, stage_in.rem} - {1'b0, stage_in.dvs};
    fits      = ~diff[mahd_pkg::NUM_BITS];
    stage_nxt = stage_in;
    stage_nxt.rem = fits ? diff[mahd_pkg::NUM_BITS-1:0] : stage_in.rem;
    stage_nxt.dvs = stage_in.dvs >> 1;
    stage_nxt.quo = {stage_in.quo[mahd_pkg::QUO_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.rem <= stage_nxt.rem;
    stage_r.dvs <= stage_nxt.dvs;
    stage_r.quo <= stage_nxt.quo;
    stage_r.res <= stage_nxt.res;
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire

// ===== test/mahd_header_checker.sv =====
// Result checker for the MPEG audio header decoder: predicts each item and compares.
`timescale 1ns / 100ps

module mahd_header_checker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic           busy,
  input  wire mahd_pkg::in_t  in_item,
  input  wire logic           out_strobe,
  input  wire mahd_pkg::out_t out_item,
  output int                  fail_count,
  output int                  pending
);

  // Bitrates in kbit/s: MPEG-1 layers I, II, III, then MPEG-2 layer I and layers II/III.
  localparam logic [8:0] BITRATE_LUT [5][16] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  // Sample rates in Hz, indexed by decoded version and rate index.
  localparam logic [15:0] SAMPLE_RATE_LUT [2][4] = '{
    '{16'd44100, 16'd48000, 16'd32000, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0}
  };

  mahd_pkg::out_t decoded_headers [$];

  // Decodes one header the way the block should.
  function automatic mahd_pkg::out_t decode_header(input mahd_pkg::in_t hdr);
    mahd_pkg::out_t res;
    logic [3:0]     br_idx;
    logic [1:0]     rate_idx;
    int unsigned    row;
    int unsigned    bits_per_sec;
    int unsigned    slot_factor;
    int unsigned    length;
    logic           bad;
    res = '0;
    res.version = hdr.header_byte1[3] ? mahd_pkg::VERSION_MPEG1 : mahd_pkg::VERSION_MPEG2;
    case (hdr.header_byte1[2:1])
      mahd_pkg::LCODE_LAYER1: res.layer = mahd_pkg::LAYER_ONE;
      mahd_pkg::LCODE_LAYER2: res.layer = mahd_pkg::LAYER_TWO;
      mahd_pkg::LCODE_LAYER3: res.layer = mahd_pkg::LAYER_THREE;
      default:                res.layer = mahd_pkg::LAYER_NONE;
    endcase
    res.crc_present = ~hdr.header_byte1[0];
    br_idx = hdr.header_byte2[7:4];
    rate_idx = hdr.header_byte2[3:2];
    res.sample_rate_hz = SAMPLE_RATE_LUT[res.version][rate_idx];
    res.padded = hdr.header_byte2[1];
    res.chan_mode = hdr.header_byte3[7:6];
    res.joint_extension = (res.chan_mode == mahd_pkg::MODE_JOINT) ?
                          hdr.header_byte3[5:4] : 2'd0;

    // The bitrate is looked up whenever the layer is known, even on error.
    if (res.layer != mahd_pkg::LAYER_NONE) begin
      if (res.version == mahd_pkg::VERSION_MPEG1) begin
        row = res.layer - 1;
      end else begin
        row = (res.layer == mahd_pkg::LAYER_ONE) ? mahd_pkg::ROW_M2_L1 :
                                                   mahd_pkg::ROW_M2_L23;
      end
      res.bitrate_kbps = BITRATE_LUT[row][br_idx];
    end
    bad = (res.layer == mahd_pkg::LAYER_NONE) ||
          (rate_idx == mahd_pkg::RATE_IDX_RESERVED) ||
          (br_idx == mahd_pkg::BR_IDX_FREE) || (br_idx == mahd_pkg::BR_IDX_BAD);

    // Frame length uses truncating division; layer I counts 4-byte slots.
    if (!bad) begin
      bits_per_sec = res.bitrate_kbps * 1000;
      if (res.layer == mahd_pkg::LAYER_ONE) begin
        length = ((12 * bits_per_sec) / res.sample_rate_hz + res.padded) * 4;
      end else begin
        slot_factor = (res.version == mahd_pkg::VERSION_MPEG2 &&
                       res.layer == mahd_pkg::LAYER_THREE) ? 72 : 144;
        length = (slot_factor * bits_per_sec) / res.sample_rate_hz + res.padded;
      end
      res.frame_length = 11'(length);
    end
    res.status = bad;
    res.data_offset = hdr.frame_offset + 32'd32 + (res.crc_present ? 32'd2 : 32'd0);
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Results are compared at the edge that ends their strobe cycle; items are
  // predicted at the edge that accepts them.
  always @(posedge clk) begin
    mahd_pkg::out_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (decoded_headers.size() == 0) begin
          $display("%0t ns: result 0x%0h arrived with no item outstanding", $time, out_item);
          fail_count++;
        end else begin
          want = decoded_headers.pop_front();
          compare_field("status", 32'(want.status), 32'(out_item.status));
          compare_field("version", 32'(want.version), 32'(out_item.version));
          compare_field("layer", 32'(want.layer), 32'(out_item.layer));
          compare_field("crc_present", 32'(want.crc_present), 32'(out_item.crc_present));
          compare_field("sample_rate_hz", 32'(want.sample_rate_hz),
                        32'(out_item.sample_rate_hz));
          compare_field("padded", 32'(want.padded), 32'(out_item.padded));
          compare_field("bitrate_kbps", 32'(want.bitrate_kbps), 32'(out_item.bitrate_kbps));
          compare_field("frame_length", 32'(want.frame_length), 32'(out_item.frame_length));
          compare_field("chan_mode", 32'(want.chan_mode), 32'(out_item.chan_mode));
          compare_field("joint_extension", 32'(want.joint_extension),
                        32'(out_item.joint_extension));
          compare_field("data_offset", want.data_offset, out_item.data_offset);
        end
      end
      if (start && !busy) begin
        decoded_headers.push_back(decode_header(in_item));
      end
      pending = decoded_headers.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the MPEG audio header decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;

  localparam int RANDOM_ITEMS = 1300;
  localparam int STALL_LIMIT = 2000;
  localparam int IN_BITS = $bits(mahd_pkg::in_t);

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  mahd_pkg::in_t  in_item;
  logic           out_strobe;
  mahd_pkg::out_t out_item;
  int             fail_count;
  int             pending;
  int             quiet_cycles;
  bit             gaps_on;

  mpeg_audio_header_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  mahd_header_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL mpeg_audio_header_decoder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one item, with random idle cycles ahead of it, and holds it until taken.
  task automatic send_header(input mahd_pkg::in_t hdr);
    while (gaps_on && $urandom_range(99) < 35) begin
      start <= 1'b0;
      in_item <= IN_BITS'({$urandom, $urandom});
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= hdr;
    do @(posedge clk); while (busy);
  endtask

  // Builds a random header; most are well formed, the rest are raw bytes.
  function automatic mahd_pkg::in_t random_header();
    mahd_pkg::in_t hdr;
    logic [1:0]    lcode;
    hdr = IN_BITS'({$urandom, $urandom});
    if ($urandom_range(99) < 80) begin
      lcode = 2'($urandom_range(3, 1));
      hdr.header_byte1[2:1] = lcode;
      hdr.header_byte2[7:4] = 4'($urandom_range(14, 1));
      hdr.header_byte2[3:2] = 2'($urandom_range(2, 0));
    end
    // Push some offsets to the ends of the range to exercise the wrap.
    case ($urandom_range(9))
      0: hdr.frame_offset = 32'hFFFF_FFFF - 32'($urandom_range(40));
      1: hdr.frame_offset = 32'($urandom_range(40));
      default: ;
    endcase
    return hdr;
  endfunction

  initial begin
    mahd_pkg::in_t directed_headers [$];
    int            k;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    quiet_cycles = 0;
    gaps_on = 1'b1;

    // Known frames, every layer and version, all error cases and offset extremes.
    directed_headers = '{
      '{8'hFB, 8'h90, 8'h44, 32'h0000_0000},
      '{8'hFE, 8'hEA, 8'h70, 32'hFFFF_FFFF},
      '{8'hFD, 8'hEA, 8'h80, 32'hFFFF_FFE0},
      '{8'hF3, 8'hEA, 8'hC0, 32'h0000_1000},
      '{8'hF6, 8'hEA, 8'h50, 32'hFFFF_FFDE},
      '{8'hF5, 8'h14, 8'h30, 32'h1234_5678},
      '{8'hF9, 8'h90, 8'h40, 32'h0000_0010},
      '{8'hF0, 8'h94, 8'h60, 32'h8000_0000},
      '{8'hFB, 8'h9C, 8'h00, 32'h0000_0020},
      '{8'hF2, 8'h5E, 8'h7F, 32'h7FFF_FFFF},
      '{8'hFB, 8'h00, 8'h40, 32'hDEAD_BEEF},
      '{8'hFB, 8'hF2, 8'h40, 32'h0000_0001},
      '{8'h00, 8'h00, 8'h00, 32'h0000_0000},
      '{8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF},
      '{8'hFF, 8'h14, 8'h60, 32'h0000_0100},
      '{8'hFB, 8'h15, 8'h50, 32'hFFFF_FFDF},
      '{8'hF2, 8'h16, 8'h7C, 32'h0000_0002},
      '{8'h1A, 8'h51, 8'h0F, 32'h7FFF_FFE0},
      '{8'h0C, 8'hE0, 8'hB3, 32'hA5A5_A5A5},
      '{8'hF7, 8'hE8, 8'h65, 32'h5A5A_5A5A}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_headers[n]) begin
      send_header(directed_headers[n]);
    end

    // Random part with one long stretch of back-to-back items.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      gaps_on = !(k >= 500 && k < 800);
      send_header(random_header());
    end
    start <= 1'b0;
    in_item <= '0;

    // Drain, then wait past the result latency for stray results.
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (mahd_pkg::LATENCY + 4) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS mpeg_audio_header_decoder");
    end else begin
      $display("FAIL mpeg_audio_header_decoder");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mahd_pkg.sv
sv/mahd_decode.sv
sv/mahd_div_cell.sv
sv/mpeg_audio_header_decoder.sv
test/mahd_header_checker.sv
test/tb.sv
